// ===== hdl/tns_pkg.sv =====
// Types, codes and constant tables for the tone note sequencer.
// Used by the top level and the testbench; no dependencies.
`default_nettype none

package tns_pkg;

    // Command codes of an input beat
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_PLAY  = 2'd2,
        CMD_NOP   = 2'd3
    } t_cmd;

    // Play phases, also reported in every result
    typedef enum logic [1:0] {
        PH_OFF   = 2'd0,
        PH_FETCH = 2'd1,
        PH_PLAY  = 2'd2,
        PH_PAUSE = 2'd3
    } t_phase;

    // Configuration register indexes
    typedef enum logic {
        REG_SONG_LENGTH = 1'b0,
        REG_PAUSE_TICKS = 1'b1
    } t_reg_index;

    localparam int NOTE_CNT = 100;
    localparam logic [6:0]  TOP_SEMITONE = 7'd99;
    localparam logic [16:0] DIV_MAX = 17'd131071;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  note_index;
        logic [6:0]  note_freq;
        logic [15:0] note_dur;
    } t_in_item;

    typedef struct packed {
        logic        spk_on;
        logic        divisor_load;
        logic [16:0] tone_divisor;
        t_phase      phase;
    } t_out_item;

    typedef struct packed {
        t_reg_index  reg_index;
        logic [15:0] wr_data;
    } t_cfg_wr;

    // Note frequencies in centihertz, C0 upward
    localparam logic [18:0] CENTI_HZ [NOTE_CNT] = '{
        19'd1635,   19'd1732,   19'd1835,   19'd1945,   19'd2060,   19'd2183,
        19'd2312,   19'd2450,   19'd2596,   19'd2750,   19'd2914,   19'd3087,
        19'd3270,   19'd3465,   19'd3671,   19'd3889,   19'd4120,   19'd4365,
        19'd4625,   19'd4900,   19'd5191,   19'd5500,   19'd5827,   19'd6174,
        19'd6541,   19'd6930,   19'd7342,   19'd7778,   19'd8241,   19'd8731,
        19'd9250,   19'd9800,   19'd10383,  19'd11000,  19'd11654,  19'd12347,
        19'd13081,  19'd13859,  19'd14683,  19'd15556,  19'd16481,  19'd17461,
        19'd18500,  19'd19600,  19'd20765,  19'd22000,  19'd23308,  19'd24694,
        19'd26163,  19'd27718,  19'd29366,  19'd31113,  19'd32963,  19'd34923,
        19'd36999,  19'd39200,  19'd41530,  19'd44000,  19'd46616,  19'd49388,
        19'd52325,  19'd55437,  19'd58733,  19'd62225,  19'd65926,  19'd69846,
        19'd73999,  19'd78399,  19'd83061,  19'd88000,  19'd93233,  19'd98777,
        19'd104650, 19'd110873, 19'd117466, 19'd124451, 19'd131851, 19'd139691,
        19'd147998, 19'd156798, 19'd166122, 19'd176000, 19'd186466, 19'd197553,
        19'd209300, 19'd221746, 19'd234932, 19'd248902, 19'd263702, 19'd279383,
        19'd295996, 19'd313596, 19'd332244, 19'd352000, 19'd372931, 19'd395107,
        19'd418601, 19'd443492, 19'd469864, 19'd497803
    };

endpackage

`default_nettype wire

// ===== hdl/tns_chan_if.sv =====
// Valid/ready channel carrying one payload type per beat.
// Payload types come from tns_pkg at the point of instantiation.
`default_nettype none

interface tns_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/tns_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module tns_ram #(
    parameter int W = 23,
    parameter int D = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                         i_wdata,
    input  wire logic                                 i_re,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire

// ===== hdl/tone_note_sequencer.sv =====
// Tone note sequencer: plays a melody from a note store, one tick beat at a time.
// Depends on tns_pkg, tns_chan_if and tns_ram.
//
//  channel  dir  payload     beat
//  i_note   in   t_in_item   tick, note write or play command
//  o_res    out  t_out_item  state after the command, one per input beat
//  i_cfg    in   t_cfg_wr    song length / pause ticks register write
//
// One input beat per cycle while i_note is ready. The first stage updates phase,
// position and speaker and reads the note store; the second stage looks up the tone
// divisor from the read data and queues the result, which leaves o_res from the queue.
// A three-entry result queue decouples o_res stalls; i_note stalls while the
// queue and the second stage together hold three beats.
// Reset clears control state only; the note store is not cleared.
`default_nettype none

module tone_note_sequencer #(
    parameter int MAX_NOTES      = 256,
    parameter int TIMER_CLOCK_HZ = 1193182
) (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    tns_chan_if.sink     i_note,
    tns_chan_if.source   o_res,
    tns_chan_if.sink     i_cfg
);
    localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int QD = 3;

    // Configuration registers
    logic [8:0]  r_song_len;
    logic [15:0] r_pause;

    // Play state
    tns_pkg::t_phase r_phase, n_phase;
    logic [8:0]      r_pos, n_pos;
    logic [15:0]     r_count, n_count;
    logic            r_cnt_pend, n_cnt_pend;
    logic            r_spk, n_spk;

    // Second stage
    logic            r_s1_valid;
    logic            r_s1_spk;
    logic            r_s1_load;
    tns_pkg::t_phase r_s1_phase;

    // Result queue
    tns_pkg::t_out_item r_q [QD];
    logic [1:0]         r_q_wr, r_q_rd, r_q_cnt;

    // Note store access
    logic                 ram_we, ram_re;
    logic [AW-1:0]        ram_waddr, ram_raddr;
    logic [22:0]          ram_wdata, ram_rdata;
    logic [AW+8:0]        waddr_ext, raddr_ext;

    tns_pkg::t_in_item    in_item;
    logic                 in_acc;
    logic                 load;
    logic [15:0]          eff_cnt;
    logic [6:0]           semi;
    logic [16:0]          div_tab [tns_pkg::NOTE_CNT];
    tns_pkg::t_out_item   res;
    logic                 q_push, q_pop;
    logic [2:0]           q_fill;

    // Divisor table, worked out at elaboration and saturated
    for (genvar g = 0; g < tns_pkg::NOTE_CNT; g++) begin : g_div
        localparam longint unsigned QUO =
            (64'(TIMER_CLOCK_HZ) * 64'd100) / tns_pkg::CENTI_HZ[g];
        assign div_tab[g] = (QUO > 64'(tns_pkg::DIV_MAX)) ? tns_pkg::DIV_MAX : 17'(QUO);
    end

    tns_ram #(
        .W (23),
        .D (MAX_NOTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign in_item = i_note.data;
    assign q_fill  = {1'b0, r_q_cnt} + {2'b00, r_s1_valid};
    assign i_note.ready = (q_fill < 3'(QD));
    assign in_acc  = i_note.valid && i_note.ready;
    assign i_cfg.ready = 1'b1;

    // Store addresses sized to the store depth
    assign waddr_ext = {{(AW+1){1'b0}}, in_item.note_index};
    assign raddr_ext = {{AW{1'b0}}, r_pos};
    assign ram_waddr = waddr_ext[AW-1:0];
    assign ram_raddr = raddr_ext[AW-1:0];
    assign ram_wdata = {in_item.note_freq, in_item.note_dur};

    // Command decode and phase machine; counter forwarded from a fresh store read
    always_comb begin
        eff_cnt    = r_cnt_pend ? ram_rdata[15:0] : r_count;
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_count    = eff_cnt;
        n_cnt_pend = 1'b0;
        n_spk      = r_spk;
        load       = 1'b0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        if (in_acc) begin
            case (in_item.cmd)
                tns_pkg::CMD_WRITE: begin
                    ram_we = (32'(in_item.note_index) < 32'(MAX_NOTES));
                end
                tns_pkg::CMD_PLAY: begin
                    n_pos   = '0;
                    n_phase = tns_pkg::PH_FETCH;
                end
                tns_pkg::CMD_TICK: begin
                    case (r_phase)
                        tns_pkg::PH_FETCH: begin
                            if (r_pos >= r_song_len || 32'(r_pos) >= 32'(MAX_NOTES)) begin
                                n_phase = tns_pkg::PH_OFF;
                            end else begin
                                ram_re     = 1'b1;
                                n_pos      = r_pos + 9'd1;
                                n_cnt_pend = 1'b1;
                                load       = 1'b1;
                                n_spk      = 1'b1;
                                n_phase    = tns_pkg::PH_PLAY;
                            end
                        end
                        tns_pkg::PH_PLAY: begin
                            if (eff_cnt <= 16'd1) begin
                                n_count = r_pause;
                                n_spk   = 1'b0;
                                n_phase = tns_pkg::PH_PAUSE;
                            end else begin
                                n_count = eff_cnt - 16'd1;
                            end
                        end
                        tns_pkg::PH_PAUSE: begin
                            if (eff_cnt <= 16'd1) begin
                                n_count = '0;
                                n_phase = tns_pkg::PH_FETCH;
                            end else begin
                                n_count = eff_cnt - 16'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // Hold play state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= tns_pkg::PH_OFF;
            r_pos      <= '0;
            r_count    <= '0;
            r_cnt_pend <= 1'b0;
            r_spk      <= 1'b0;
            r_song_len <= '0;
            r_pause    <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_count    <= n_count;
            r_cnt_pend <= n_cnt_pend;
            r_spk      <= n_spk;
            r_s1_valid <= in_acc;
            if (i_cfg.valid) begin
                case (i_cfg.data.reg_index)
                    tns_pkg::REG_SONG_LENGTH: r_song_len <= i_cfg.data.wr_data[8:0];
                    tns_pkg::REG_PAUSE_TICKS: r_pause    <= i_cfg.data.wr_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Advance the beat's status to the second stage
    always_ff @(posedge i_clk) begin
        r_s1_spk   <= n_spk;
        r_s1_load  <= load;
        r_s1_phase <= n_phase;
    end

    // Second stage: clamp the semitone and look up the divisor
    always_comb begin
        semi = (ram_rdata[22:16] > tns_pkg::TOP_SEMITONE) ? tns_pkg::TOP_SEMITONE
                                                          : ram_rdata[22:16];
        res.spk_on       = r_s1_spk;
        res.divisor_load = r_s1_load;
        res.tone_divisor = r_s1_load ? div_tab[semi] : '0;
        res.phase        = r_s1_phase;
    end

    assign q_push = r_s1_valid;
    assign q_pop  = o_res.valid && o_res.ready;

    // Result queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wr  <= '0;
            r_q_rd  <= '0;
            r_q_cnt <= '0;
        end else begin
            if (q_push) begin
                r_q_wr <= (r_q_wr == 2'(QD - 1)) ? 2'd0 : r_q_wr + 2'd1;
            end
            if (q_pop) begin
                r_q_rd <= (r_q_rd == 2'(QD - 1)) ? 2'd0 : r_q_rd + 2'd1;
            end
            r_q_cnt <= r_q_cnt + 2'(q_push) - 2'(q_pop);
        end
    end

    // Result queue storage
    always_ff @(posedge i_clk) begin
        if (q_push) begin
            r_q[r_q_wr] <= res;
        end
    end

    assign o_res.valid = (r_q_cnt != 2'd0);
    assign o_res.data  = r_q[r_q_rd];
endmodule

`default_nettype wire

// ===== verif/tone_note_sequencer_tb.sv =====
// Testbench for tone_note_sequencer: directed and random command beats, checked
// against a cycle-free prediction of the melody state machine and tone divisors.
// Depends on tns_pkg, tns_chan_if and the tone_note_sequencer RTL.
`timescale 1ns / 100ps

module tone_note_sequencer_tb;

    localparam int CLK_PERIOD      = 10;
    localparam int MAX_NOTES       = 256;
    localparam int TIMER_HZ        = 1193182;
    localparam int MAX_GAP         = 9;
    localparam int DRAIN_CYCLES    = 10;
    localparam int RANDOM_ROUNDS   = 5;
    localparam int ROUND_ITEMS     = 45;
    localparam int FULL_SONG_TICKS = 30;
    localparam int REPORT_LIMIT    = 10;
    localparam int TIMEOUT_NS      = 5_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tns_chan_if #(.t_payload(tns_pkg::t_in_item))  note_if ();
    tns_chan_if #(.t_payload(tns_pkg::t_out_item)) res_if ();
    tns_chan_if #(.t_payload(tns_pkg::t_cfg_wr))   cfg_if ();

    tone_note_sequencer #(
        .MAX_NOTES      (MAX_NOTES),
        .TIMER_CLOCK_HZ (TIMER_HZ)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_note  (note_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    // Predicted sequencer state and registers
    logic [8:0]       song_len;
    logic [15:0]      pause_len;
    tns_pkg::t_phase  mel_phase;
    logic [8:0]       mel_pos;
    logic [17:0]      mel_count;
    logic             mel_speaker;
    logic [22:0]      note_mem [MAX_NOTES];

    tns_pkg::t_out_item expected_results [$];
    int unsigned        mismatch_count = 0;
    int unsigned        hold_left = 0;
    bit                 gaps_on;
    bit                 stalls_on;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Timer clock over note frequency, truncated, with the top semitone clamp
    function automatic logic [16:0] divisor_of(input logic [6:0] semitone);
        logic [6:0]      semi;
        longint unsigned quotient;
        semi = (semitone > tns_pkg::TOP_SEMITONE) ? tns_pkg::TOP_SEMITONE : semitone;
        quotient = (64'(TIMER_HZ) * 64'd100) / 64'(tns_pkg::CENTI_HZ[semi]);
        if (quotient > 64'(tns_pkg::DIV_MAX))
            return tns_pkg::DIV_MAX;
        return quotient[16:0];
    endfunction

    // Advance the predicted state by one command and return the result beat
    function automatic tns_pkg::t_out_item melody_step(input tns_pkg::t_in_item it);
        tns_pkg::t_out_item r;
        logic [22:0]        word;
        r = '0;
        case (it.cmd)
            tns_pkg::CMD_WRITE: note_mem[it.note_index] = {it.note_freq, it.note_dur};
            tns_pkg::CMD_PLAY: begin
                mel_pos   = '0;
                mel_phase = tns_pkg::PH_FETCH;
            end
            tns_pkg::CMD_TICK: begin
                case (mel_phase)
                    tns_pkg::PH_FETCH: begin
                        if (mel_pos >= song_len || mel_pos >= MAX_NOTES) begin
                            mel_phase = tns_pkg::PH_OFF;
                        end else begin
                            word           = note_mem[mel_pos[7:0]];
                            mel_pos        = mel_pos + 9'd1;
                            mel_count      = 18'(word[15:0]);
                            r.tone_divisor = divisor_of(word[22:16]);
                            r.divisor_load = 1'b1;
                            mel_speaker    = 1'b1;
                            mel_phase      = tns_pkg::PH_PLAY;
                        end
                    end
                    tns_pkg::PH_PLAY: begin
                        if (mel_count <= 18'd1) begin
                            mel_count   = 18'(pause_len);
                            mel_speaker = 1'b0;
                            mel_phase   = tns_pkg::PH_PAUSE;
                        end else begin
                            mel_count = mel_count - 18'd1;
                        end
                    end
                    tns_pkg::PH_PAUSE: begin
                        if (mel_count <= 18'd1) begin
                            mel_count = '0;
                            mel_phase = tns_pkg::PH_FETCH;
                        end else begin
                            mel_count = mel_count - 18'd1;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.spk_on = mel_speaker;
        r.phase  = mel_phase;
        return r;
    endfunction

    function automatic tns_pkg::t_in_item note_beat(input tns_pkg::t_cmd c,
                                                    input logic [7:0] idx,
                                                    input logic [6:0] frq,
                                                    input logic [15:0] dur);
        tns_pkg::t_in_item it;
        it.cmd        = c;
        it.note_index = idx;
        it.note_freq  = frq;
        it.note_dur   = dur;
        return it;
    endfunction

    // Mostly ticks with some writes, rare restarts and no-ops; durations mostly short
    function automatic tns_pkg::t_in_item random_note();
        tns_pkg::t_in_item it;
        int unsigned       roll;
        roll          = $urandom_range(0, 99);
        it.note_index = 8'($urandom_range(0, 255));
        it.note_freq  = 7'($urandom_range(0, 127));
        it.note_dur   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        if (roll < 72)
            it.cmd = tns_pkg::CMD_TICK;
        else if (roll < 88)
            it.cmd = tns_pkg::CMD_WRITE;
        else if (roll < 95)
            it.cmd = tns_pkg::CMD_PLAY;
        else
            it.cmd = tns_pkg::CMD_NOP;
        return it;
    endfunction

    // Drive one command beat, after a random gap when gaps are on, and predict its result on acceptance
    task automatic send_note(input tns_pkg::t_in_item it);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0) begin
            note_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        note_if.valid <= 1'b1;
        note_if.data  <= it;
        do @(posedge i_clk); while (!note_if.ready);
        expected_results.push_back(melody_step(it));
    endtask

    task automatic wait_results_drained();
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    // Write both registers once the block has delivered every pending result
    task automatic set_registers(input logic [8:0] length, input logic [15:0] pause);
        note_if.valid <= 1'b0;
        wait_results_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= '{reg_index: tns_pkg::REG_SONG_LENGTH, wr_data: 16'(length)};
        do @(posedge i_clk); while (!cfg_if.ready);
        song_len = length;
        cfg_if.data <= '{reg_index: tns_pkg::REG_PAUSE_TICKS, wr_data: pause};
        do @(posedge i_clk); while (!cfg_if.ready);
        pause_len = pause;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic check_result(input tns_pkg::t_out_item got);
        tns_pkg::t_out_item want;
        if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("ERROR %0t: unexpected result spk=%0d load=%0d div=%0d phase=%0d",
                         $time, got.spk_on, got.divisor_load, got.tone_divisor,
                         got.phase);
            return;
        end
        want = expected_results.pop_front();
        if (got.spk_on !== want.spk_on || got.divisor_load !== want.divisor_load
                || got.tone_divisor !== want.tone_divisor || got.phase !== want.phase) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("ERROR %0t: expected spk=%0d load=%0d div=%0d phase=%0d",
                         $time, want.spk_on, want.divisor_load, want.tone_divisor,
                         want.phase);
                $display("      got      spk=%0d load=%0d div=%0d phase=%0d",
                         got.spk_on, got.divisor_load, got.tone_divisor, got.phase);
            end
        end
    endtask

    // Check each result beat, then, when stalls are on, hold ready low for a random stall
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            check_result(res_if.data);
            hold_left = stalls_on ? $urandom_range(0, MAX_GAP) : 0;
        end else if (hold_left != 0) begin
            hold_left--;
        end
        res_if.ready <= (hold_left == 0);
    end

    // Commands from the off phase, then an empty song
    task automatic test_idle_commands();
        set_registers(9'd0, 16'd0);
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_NOP, 8'd255, 7'd127, 16'hFFFF));
        send_note(note_beat(tns_pkg::CMD_WRITE, 8'd255, 7'd50, 16'hFFFF));
        send_note(note_beat(tns_pkg::CMD_PLAY, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
    endtask

    // Three notes at the pitch extremes, one above the table top, played to the end
    task automatic test_short_song();
        set_registers(9'd3, 16'd0);
        send_note(note_beat(tns_pkg::CMD_WRITE, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_WRITE, 8'd1, tns_pkg::TOP_SEMITONE, 16'd1));
        send_note(note_beat(tns_pkg::CMD_WRITE, 8'd2, 7'd127, 16'd2));
        send_note(note_beat(tns_pkg::CMD_PLAY, 8'd0, 7'd0, 16'd0));
        do send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        while (mel_phase != tns_pkg::PH_OFF);
    endtask

    // Restart while playing and pausing, write during play, longest counts
    task automatic test_restart_and_long_counts();
        set_registers(9'd2, 16'hFFFF);
        send_note(note_beat(tns_pkg::CMD_WRITE, 8'd0, 7'd1, 16'hFFFF));
        send_note(note_beat(tns_pkg::CMD_PLAY, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_PLAY, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_WRITE, 8'd0, 7'd2, 16'd0));
        send_note(note_beat(tns_pkg::CMD_PLAY, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_PLAY, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_NOP, 8'd0, 7'd0, 16'd0));
        send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
    endtask

    // Fill the whole store with short notes and play the opening of a full-length song
    task automatic test_full_song();
        for (int i = 0; i < MAX_NOTES; i++)
            send_note(note_beat(tns_pkg::CMD_WRITE, 8'(i), 7'($urandom_range(0, 127)),
                                16'($urandom_range(0, 1))));
        set_registers(9'd256, 16'd0);
        send_note(note_beat(tns_pkg::CMD_PLAY, 8'd0, 7'd0, 16'd0));
        repeat (FULL_SONG_TICKS)
            send_note(note_beat(tns_pkg::CMD_TICK, 8'd0, 7'd0, 16'd0));
    endtask

    // Random rounds, each with its own registers and idling mix
    task automatic test_random_play();
        logic [8:0]  length;
        logic [15:0] pause;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            gaps_on   = (round >= 2);
            stalls_on = (round != 0) && (round != 2);
            length = ($urandom_range(0, 3) == 0) ? 9'd256 : 9'($urandom_range(0, 6));
            pause  = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
            set_registers(length, pause);
            repeat (ROUND_ITEMS) send_note(random_note());
        end
    endtask

    initial begin
        note_if.valid = 1'b0;
        note_if.data  = '0;
        cfg_if.valid  = 1'b0;
        cfg_if.data   = '0;
        gaps_on       = 1'b1;
        stalls_on     = 1'b1;
        song_len      = '0;
        pause_len     = '0;
        mel_phase     = tns_pkg::PH_OFF;
        mel_pos       = '0;
        mel_count     = '0;
        mel_speaker   = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_commands();
        test_short_song();
        test_restart_and_long_counts();
        test_full_song();
        test_random_play();

        // Drop valid, let the last results arrive and watch for strays
        note_if.valid <= 1'b0;
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Hard stop far beyond the slowest correct run
    initial begin
        #(TIMEOUT_NS);
        $display("Verification failed");
        $finish;
    end

endmodule
